>>> rtl/rhp_pkg.sv
// Shared types and codes for the RTP header parser.
package rhp_pkg;

  // Parse phases of the byte sequencer
  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_CSRC    = 3'd1,
    PH_EXTHEAD = 3'd2,
    PH_EXTBODY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HDR_OK      = 3'd0,
    ST_BAD_HDR     = 3'd1,
    ST_CSRC_CUT    = 3'd2,
    ST_EXTHEAD_CUT = 3'd3,
    ST_EXTBODY_CUT = 3'd4,
    ST_PAYLOAD     = 3'd5
  } status_t;

  localparam int unsigned PosW = 19;

  // One result item
  typedef struct packed {
    status_t           status;
    logic              padding;
    logic              extension;
    logic [3:0]        csrc_count;
    logic              marker;
    logic [6:0]        payload_type;
    logic [15:0]       sequence_res;
    logic [31:0]       timestamp;
    logic [31:0]       ssrc;
    logic [PosW-1:0]   header_length;
    logic [7:0]        payload_byte;
    logic              packet_done;
  } res_t;

endpackage

>>> rtl/rtp_header_parser.sv
// RTP header parser: byte-serial fixed header, CSRC and extension decode with payload pass-through.
//
// Takes one packet byte per transfer, in wire order, with in_end_of_packet on the last
// byte. The fixed 12-byte header is decoded big-endian; the CSRC words and the header
// extension (4-byte head, then the body whose length in 32-bit words sits in the last two
// head bytes) are skipped. On the final header byte one status-0 result carries the
// decoded fields and the total header length; each later byte of the packet comes out as a
// status-5 payload result. A bad version (checked on the first byte) or a packet that
// ends inside the header gives one error result (status 1 to 4); when that byte is not the
// last one, the rest of the packet up to end of packet is dropped without results.
// Rate: one byte per clock while out_ready is high; output stalls hold the input. A byte
// passes an input register and the decode logic into the result register; the input is
// stalled only while the result register holds an untaken result. The decode for a
// byte finishes in the cycle it leaves the input register, so the next byte sees the
// updated parse state at once.
module rtp_header_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_packet,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic                     out_padding,
  output logic                     out_extension,
  output logic [3:0]               out_csrc_count,
  output logic                     out_marker,
  output logic [6:0]               out_payload_type,
  output logic [15:0]              out_sequence_res,
  output logic [31:0]              out_timestamp,
  output logic [31:0]              out_ssrc,
  output logic [rhp_pkg::PosW-1:0] out_header_length,
  output logic [7:0]               out_payload_byte,
  output logic                     out_packet_done
);
  import rhp_pkg::*;

  // Byte positions inside the fixed header
  localparam logic [PosW-1:0] PosSeq   = PosW'(2);
  localparam logic [PosW-1:0] PosTs    = PosW'(4);
  localparam logic [PosW-1:0] PosSsrc  = PosW'(8);
  localparam logic [PosW-1:0] PosLast  = PosW'(11);
  localparam logic [PosW-1:0] FixedLen = PosW'(12);

  // Input register
  logic            in_vld_r;
  logic [7:0]      byte_r;
  logic            eop_r;

  // Parse state
  phase_t          phase_r, phase_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            discard_r, discard_nxt;
  logic [15:0]     hdr_r, hdr_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic [31:0]     ts_r, ts_nxt;
  logic [31:0]     ssrc_r, ssrc_nxt;
  logic [7:0]      ewc_hi_r, ewc_hi_nxt;
  logic [PosW-1:0] hep_r, hep_nxt;

  // Result register
  logic            out_vld_r;
  res_t            res_r, res_nxt;

  logic            adv;
  logic            proc;
  logic            has_res;
  logic            emit_hdr;
  logic            err_flag;
  status_t         err_code;
  logic [PosW:0]   pos_inc;
  logic [15:0]     ewc_full;
  logic [1:0]      ext_k;

  // The result register can take a new value when empty or being drained
  assign adv      = !out_vld_r || out_ready;
  assign proc     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  assign pos_inc  = {1'b0, pos_r} + (PosW+1)'(1);
  assign ewc_full = {ewc_hi_r, byte_r};
  assign ext_k    = pos_r[1:0] - hep_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eop_r  <= in_end_of_packet;
    end
  end

  // Parse state register: advance only when the held byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIXED;
      pos_r     <= '0;
      discard_r <= 1'b0;
    end else if (proc) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      discard_r <= discard_nxt;
    end
    if (proc) begin
      hdr_r    <= hdr_nxt;
      seq_r    <= seq_nxt;
      ts_r     <= ts_nxt;
      ssrc_r   <= ssrc_nxt;
      ewc_hi_r <= ewc_hi_nxt;
      hep_r    <= hep_nxt;
    end
  end

  // Next parse state and the result for the held byte
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    discard_nxt = discard_r;
    hdr_nxt     = hdr_r;
    seq_nxt     = seq_r;
    ts_nxt      = ts_r;
    ssrc_nxt    = ssrc_r;
    ewc_hi_nxt  = ewc_hi_r;
    hep_nxt     = hep_r;
    res_nxt     = '0;
    has_res     = 1'b0;
    emit_hdr    = 1'b0;
    err_flag    = 1'b0;
    err_code    = ST_BAD_HDR;

    if (discard_r) begin
      // Drop bytes until the end of the bad packet
      if (eop_r) begin
        discard_nxt = 1'b0;
        phase_nxt   = PH_FIXED;
        pos_nxt     = '0;
      end
    end else begin
      unique case (phase_r)
        PH_FIXED: begin
          if (pos_r < PosSeq) begin
            hdr_nxt = {hdr_r[7:0], byte_r};
          end else if (pos_r < PosTs) begin
            seq_nxt = {seq_r[7:0], byte_r};
          end else if (pos_r < PosSsrc) begin
            ts_nxt = {ts_r[23:0], byte_r};
          end else begin
            ssrc_nxt = {ssrc_r[23:0], byte_r};
          end
          if (pos_r == '0 && byte_r[7:6] != 2'b10) begin
            err_flag = 1'b1;
            err_code = ST_BAD_HDR;
          end else if (pos_r >= PosLast) begin
            hep_nxt = FixedLen + PosW'({hdr_r[11:8], 2'b00});
            if (hdr_r[11:8] != 4'd0) begin
              phase_nxt = PH_CSRC;
              err_flag  = eop_r;
              err_code  = ST_CSRC_CUT;
            end else if (hdr_r[12]) begin
              phase_nxt = PH_EXTHEAD;
              err_flag  = eop_r;
              err_code  = ST_EXTHEAD_CUT;
            end else begin
              emit_hdr  = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end
          end else if (eop_r) begin
            err_flag = 1'b1;
            err_code = ST_BAD_HDR;
          end
        end
        PH_CSRC: begin
          if (pos_inc >= {1'b0, hep_r}) begin
            if (hdr_r[12]) begin
              phase_nxt = PH_EXTHEAD;
              err_flag  = eop_r;
              err_code  = ST_EXTHEAD_CUT;
            end else begin
              emit_hdr  = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end
          end else if (eop_r) begin
            err_flag = 1'b1;
            err_code = ST_CSRC_CUT;
          end
        end
        PH_EXTHEAD: begin
          if (ext_k == 2'd2) begin
            ewc_hi_nxt = byte_r;
          end
          if (ext_k == 2'd3) begin
            // Body length in words; total header end moves past head and body
            hep_nxt = hep_r + PosW'(4) + PosW'({ewc_full, 2'b00});
            if (ewc_full == 16'd0) begin
              emit_hdr  = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_EXTBODY;
              err_flag  = eop_r;
              err_code  = ST_EXTBODY_CUT;
            end
          end else if (eop_r) begin
            err_flag = 1'b1;
            err_code = ST_EXTHEAD_CUT;
          end
        end
        PH_EXTBODY: begin
          if (pos_inc >= {1'b0, hep_r}) begin
            emit_hdr  = 1'b1;
            phase_nxt = PH_PAYLOAD;
          end else if (eop_r) begin
            err_flag = 1'b1;
            err_code = ST_EXTBODY_CUT;
          end
        end
        PH_PAYLOAD: begin
          res_nxt.status       = ST_PAYLOAD;
          res_nxt.payload_byte = byte_r;
          has_res              = 1'b1;
        end
        default: begin
          res_nxt.status       = ST_PAYLOAD;
          res_nxt.payload_byte = byte_r;
          has_res              = 1'b1;
        end
      endcase

      if (emit_hdr) begin
        res_nxt.status        = ST_HDR_OK;
        res_nxt.padding       = hdr_nxt[13];
        res_nxt.extension     = hdr_nxt[12];
        res_nxt.csrc_count    = hdr_nxt[11:8];
        res_nxt.marker        = hdr_nxt[7];
        res_nxt.payload_type  = hdr_nxt[6:0];
        res_nxt.sequence_res  = seq_nxt;
        res_nxt.timestamp     = ts_nxt;
        res_nxt.ssrc          = ssrc_nxt;
        res_nxt.header_length = hep_nxt;
        has_res               = 1'b1;
      end
      if (err_flag) begin
        res_nxt.status = err_code;
        has_res        = 1'b1;
      end
      res_nxt.packet_done = has_res && eop_r;

      // Packet end restarts the parse; an error drops the rest of the packet
      if (eop_r) begin
        phase_nxt   = PH_FIXED;
        pos_nxt     = '0;
        discard_nxt = 1'b0;
      end else if (err_flag) begin
        discard_nxt = 1'b1;
      end else if (phase_nxt != PH_PAYLOAD) begin
        pos_nxt = pos_inc[PosW-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= proc && has_res;
    end
    if (proc && has_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = res_r.status;
  assign out_padding       = res_r.padding;
  assign out_extension     = res_r.extension;
  assign out_csrc_count    = res_r.csrc_count;
  assign out_marker        = res_r.marker;
  assign out_payload_type  = res_r.payload_type;
  assign out_sequence_res  = res_r.sequence_res;
  assign out_timestamp     = res_r.timestamp;
  assign out_ssrc          = res_r.ssrc;
  assign out_header_length = res_r.header_length;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_packet_done   = res_r.packet_done;

  // A dropped byte never produces a result
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc && discard_r |=> !out_vld_r)
    else $error("result produced while dropping a bad packet");

  // Every payload-phase byte becomes one payload result
  a_payload_passes: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !discard_r && phase_r == PH_PAYLOAD |=> out_vld_r && res_r.status == ST_PAYLOAD)
    else $error("payload byte lost");

  // End of packet always restarts the parse at the fixed header
  a_eop_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && eop_r |=> phase_r == PH_FIXED && pos_r == '0 && !discard_r)
    else $error("parser not restarted after end of packet");

  // The fixed header never runs past its last byte
  a_fixed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIXED |-> pos_r <= PosLast)
    else $error("fixed header position out of range");

endmodule
